[rtl/ppiu_pkg.sv]
// ppiu_pkg: shared types and constants of the packed palette index unpacker
// no dependencies; imported by every module of the block except ppiu_fifo
`default_nettype none

package ppiu_pkg;

   localparam int WORD_BITS  = 64;
   localparam int SLOT_W     = 12;
   localparam int COLOR_W    = 8;
   localparam int POS_W      = 12;
   localparam int BSIZE_W    = 5;
   localparam int PSIZE_W    = 13;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_CW    = $clog2(RSP_DEPTH + 1);

   // item kinds
   localparam logic FUNC_PAL_WRITE = 1'b0;
   localparam logic FUNC_DATA_WORD = 1'b1;

   // span modes
   localparam logic SPAN_LEGACY  = 1'b0;
   localparam logic SPAN_ALIGNED = 1'b1;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_SPAN_MODE    = 2'd0;
   localparam logic [1:0] REG_BIT_SIZE     = 2'd1;
   localparam logic [1:0] REG_PALETTE_SIZE = 2'd2;

   localparam logic               RST_SPAN_MODE    = SPAN_ALIGNED;
   localparam logic [BSIZE_W-1:0] RST_BIT_SIZE     = 5'd4;
   localparam logic [PSIZE_W-1:0] RST_PALETTE_SIZE = 13'd0;

   typedef struct packed {
      logic               span_mode;
      logic [BSIZE_W-1:0] bit_size;
      logic [PSIZE_W-1:0] palette_size;
   } cfg_type;

   typedef struct packed {
      logic                 func;
      logic                 slot_ok;
      logic [SLOT_W-1:0]    slot;
      logic [COLOR_W-1:0]   color;
      logic                 water;
      logic [WORD_BITS-1:0] word;
   } cmd_type;

   typedef struct packed {
      logic [COLOR_W-1:0] block_color;
      logic               block_water;
      logic [POS_W-1:0]   block_position;
      logic               any_block;
      logic               last;
      logic               section_end;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/packed_palette_index_unpacker.sv]
// channel   | handshake                    | payload
// ----------+------------------------------+------------------------------------------
// input     | push / full                  | req_func, req_pal_slot, req_pal_color,
//           |                              | req_pal_water, req_data_word
// result    | empty / pop                  | rsp_block_color .. rsp_section_end
// config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// one result per cycle while the result queue has room: a word yields one result per index
// (16 at 4-bit size, up to 64 at 1-bit size); the single palette read port sets this rate.
// a beat passes the command queue, then the sequencer and lookup registers, before the result queue.
// reset empties both queues and restores register defaults; the palette store is not cleared.
// full stalls only when the two-entry command queue is full; pop stalls hold back issue
// once the four-entry result queue has no free slot.
//
// top level; depends on ppiu_pkg, ppiu_csr, ppiu_front, ppiu_back and ppiu_fifo
`default_nettype none

module packed_palette_index_unpacker
   import ppiu_pkg::*;
#(
   parameter int BLOCKS_PER_SECTION = 4096,
   parameter int PALETTE_DEPTH      = 4096,
   parameter int MAX_INDEX_BITS     = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic                  req_func,
   input  wire logic [SLOT_W-1:0]     req_pal_slot,
   input  wire logic [COLOR_W-1:0]    req_pal_color,
   input  wire logic                  req_pal_water,
   input  wire logic [WORD_BITS-1:0]  req_data_word,
   output logic                       empty,
   input  wire logic                  pop,
   output logic [COLOR_W-1:0]         rsp_block_color,
   output logic                       rsp_block_water,
   output logic [POS_W-1:0]           rsp_block_position,
   output logic                       rsp_any_block,
   output logic                       rsp_last,
   output logic                       rsp_section_end,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type           cfg;
   cmd_type           cmd;
   logic              cmd_valid, cmd_pop;
   logic [RSP_CW-1:0] rsp_level;
   logic              rsp_push;
   rsp_type           rsp_new, rsp_head;

   ppiu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ppiu_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_func      (req_func),
      .req_pal_slot  (req_pal_slot),
      .req_pal_color (req_pal_color),
      .req_pal_water (req_pal_water),
      .req_data_word (req_data_word),
      .cmd           (cmd),
      .cmd_valid     (cmd_valid),
      .cmd_pop       (cmd_pop)
   );

   ppiu_back #(
      .BLOCKS_PER_SECTION (BLOCKS_PER_SECTION),
      .PALETTE_DEPTH      (PALETTE_DEPTH),
      .MAX_INDEX_BITS     (MAX_INDEX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_level (rsp_level),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_new)
   );

   // issue is credit-checked against the level, so this queue never overflows
   ppiu_fifo #(
      .data_type (rsp_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_new),
      .full  (),
      .pop   (pop),
      .rdata (rsp_head),
      .empty (empty),
      .level (rsp_level)
   );

   assign rsp_block_color    = rsp_head.block_color;
   assign rsp_block_water    = rsp_head.block_water;
   assign rsp_block_position = rsp_head.block_position;
   assign rsp_any_block      = rsp_head.any_block;
   assign rsp_last           = rsp_head.last;
   assign rsp_section_end    = rsp_head.section_end;

endmodule

`default_nettype wire

[rtl/ppiu_fifo.sv]
// ppiu_fifo: small synchronous queue of register entries with a fill level
// depends on nothing; used for the command queue and the result queue
`default_nettype none

module ppiu_fifo #(
   parameter type data_type = logic,
   parameter int  DEPTH     = 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire data_type                     wdata,
   output logic                              full,
   input  wire logic                         pop,
   output data_type                          rdata,
   output logic                              empty,
   output logic [$clog2(DEPTH + 1)-1:0]      level
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   data_type        ent_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign level   = cnt_ff;
   assign rdata   = ent_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

[rtl/ppiu_csr.sv]
// ppiu_csr: configuration registers behind the apb-style port
// depends on ppiu_pkg
`default_nettype none

module ppiu_csr
   import ppiu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   logic               span_mode_ff, span_mode_in;
   logic [BSIZE_W-1:0] bit_size_ff, bit_size_in;
   logic [PSIZE_W-1:0] palette_size_ff, palette_size_in;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      span_mode_in    = span_mode_ff;
      bit_size_in     = bit_size_ff;
      palette_size_in = palette_size_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_SPAN_MODE:    span_mode_in    = pwdata[0];
            REG_BIT_SIZE:     bit_size_in     = pwdata[BSIZE_W-1:0];
            REG_PALETTE_SIZE: palette_size_in = pwdata[PSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_mode_ff    <= RST_SPAN_MODE;
         bit_size_ff     <= RST_BIT_SIZE;
         palette_size_ff <= RST_PALETTE_SIZE;
      end else begin
         span_mode_ff    <= span_mode_in;
         bit_size_ff     <= bit_size_in;
         palette_size_ff <= palette_size_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SPAN_MODE:    prdata = CSR_DATA_W'(span_mode_ff);
         REG_BIT_SIZE:     prdata = CSR_DATA_W'(bit_size_ff);
         REG_PALETTE_SIZE: prdata = CSR_DATA_W'(palette_size_ff);
         default:          prdata = '0;
      endcase
   end

   assign cfg.span_mode    = span_mode_ff;
   assign cfg.bit_size     = bit_size_ff;
   assign cfg.palette_size = palette_size_ff;

endmodule

`default_nettype wire

[rtl/ppiu_front.sv]
// ppiu_front: accepts input beats, classifies them and queues commands
// depends on ppiu_pkg and ppiu_fifo
`default_nettype none

module ppiu_front
   import ppiu_pkg::*;
#(
   parameter int PALETTE_DEPTH = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic                 req_func,
   input  wire logic [SLOT_W-1:0]    req_pal_slot,
   input  wire logic [COLOR_W-1:0]   req_pal_color,
   input  wire logic                 req_pal_water,
   input  wire logic [WORD_BITS-1:0] req_data_word,
   output cmd_type                   cmd,
   output logic                      cmd_valid,
   input  wire logic                 cmd_pop
);

   cmd_type cmd_new;
   logic    cmd_empty;

   // slots past the palette depth are dropped by the back end
   always_comb begin
      cmd_new.func    = req_func;
      cmd_new.slot_ok = (32'(req_pal_slot) < PALETTE_DEPTH);
      cmd_new.slot    = req_pal_slot;
      cmd_new.color   = req_pal_color;
      cmd_new.water   = req_pal_water;
      cmd_new.word    = req_data_word;
   end

   ppiu_fifo #(
      .data_type (cmd_type),
      .DEPTH     (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (cmd_new),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (cmd),
      .empty (cmd_empty),
      .level ()
   );

   assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

[rtl/ppiu_back.sv]
// ppiu_back: palette store, index sequencer and lookup stage
// depends on ppiu_pkg; feeds the result queue in the top level
`default_nettype none

module ppiu_back
   import ppiu_pkg::*;
#(
   parameter int BLOCKS_PER_SECTION = 4096,
   parameter int PALETTE_DEPTH      = 4096,
   parameter int MAX_INDEX_BITS     = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire cmd_type           cmd,
   input  wire logic              cmd_valid,
   output logic                   cmd_pop,
   input  wire logic [RSP_CW-1:0] rsp_level,
   output logic                   rsp_push,
   output rsp_type                rsp_data
);

   localparam int AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CNT_W = $clog2(BLOCKS_PER_SECTION);
   localparam int BS_W  = $clog2(MAX_INDEX_BITS + 1);
   localparam int MW    = MAX_INDEX_BITS;

   logic [COLOR_W:0] pal_mem [PALETTE_DEPTH];

   // sequencer state
   logic                 busy_ff, busy_in;
   logic [WORD_BITS-1:0] cur_ff, cur_in;
   logic [6:0]           pos_ff, pos_in;
   logic                 join_ff, join_in;
   logic [MW-1:0]        carry_ff, carry_in;
   logic                 carry_pend_ff, carry_pend_in;
   logic [BS_W-1:0]      np_ff, np_in;
   logic [CNT_W-1:0]     blk_cnt_ff, blk_cnt_in;

   // lookup stage
   logic                 b_valid_ff;
   logic [POS_W-1:0]     b_pos_ff;
   logic                 b_ok_ff, b_last_ff, b_end_ff;
   logic [COLOR_W:0]     rd_ff;
   logic                 seen_ff, seen_in;

   logic [BS_W-1:0]      b_eff, sh;
   logic [MW-1:0]        mask, idx;
   logic [7:0]           nxt_pos;
   logic [WORD_BITS-1:0] nxt_cur;
   logic                 can_issue, step, sec_end, fits_next, done;
   logic                 idx_ok, take, pal_wr;
   logic [COLOR_W-1:0]   color;
   logic                 hit, any_now;

   always_comb begin
      if (cfg.bit_size == '0) begin
         b_eff = BS_W'(1);
      end else if (32'(cfg.bit_size) > MAX_INDEX_BITS) begin
         b_eff = BS_W'(MAX_INDEX_BITS);
      end else begin
         b_eff = BS_W'(cfg.bit_size);
      end
   end

   assign mask      = ~({MW{1'b1}} << b_eff);
   assign can_issue = (32'(rsp_level) + 32'(b_valid_ff)) < RSP_DEPTH;
   assign step      = busy_ff && can_issue;
   assign sec_end   = (blk_cnt_ff == CNT_W'(BLOCKS_PER_SECTION - 1));
   assign sh        = (b_eff > np_ff) ? b_eff - np_ff : '0;

   always_comb begin
      if (join_ff) begin
         // index straddling the previous word: carried low bits plus new bits
         idx     = (carry_ff | (cur_ff[MW-1:0] << sh)) & mask;
         nxt_pos = 8'(np_ff);
         nxt_cur = cur_ff >> np_ff;
      end else begin
         idx     = cur_ff[MW-1:0] & mask;
         nxt_pos = 8'(pos_ff) + 8'(b_eff);
         nxt_cur = cur_ff >> b_eff;
      end
   end

   assign fits_next = (9'(nxt_pos) + 9'(b_eff)) <= 9'(WORD_BITS);
   assign done      = sec_end || !fits_next;
   assign idx_ok    = (32'(idx) < 32'(cfg.palette_size)) && (32'(idx) < PALETTE_DEPTH);
   assign take      = cmd_valid && (!busy_ff || (step && done));
   assign cmd_pop   = take;
   assign pal_wr    = take && (cmd.func == FUNC_PAL_WRITE) && cmd.slot_ok;

   always_comb begin
      busy_in       = busy_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      join_in       = join_ff;
      carry_in      = carry_ff;
      carry_pend_in = carry_pend_ff;
      np_in         = np_ff;
      blk_cnt_in    = blk_cnt_ff;

      if (step) begin
         cur_in  = nxt_cur;
         pos_in  = 7'(nxt_pos);
         join_in = 1'b0;
         if (join_ff) begin
            carry_pend_in = 1'b0;
            carry_in      = '0;
            np_in         = '0;
         end
         if (sec_end) begin
            blk_cnt_in    = '0;
            carry_pend_in = 1'b0;
            carry_in      = '0;
            np_in         = '0;
         end else begin
            blk_cnt_in = blk_cnt_ff + 1'b1;
            // top bits left over in legacy mode start the next index
            if (!fits_next && cfg.span_mode == SPAN_LEGACY &&
                nxt_pos < 8'(WORD_BITS)) begin
               carry_in      = nxt_cur[MW-1:0] & mask;
               np_in         = BS_W'(nxt_pos + 8'(b_eff) - 8'(WORD_BITS));
               carry_pend_in = 1'b1;
            end
         end
         if (done) begin
            busy_in = 1'b0;
         end
      end

      if (take && cmd.func == FUNC_DATA_WORD) begin
         busy_in = 1'b1;
         cur_in  = cmd.word;
         pos_in  = '0;
         if (cfg.span_mode == SPAN_ALIGNED) begin
            join_in       = 1'b0;
            carry_pend_in = 1'b0;
            carry_in      = '0;
            np_in         = '0;
         end else begin
            join_in = carry_pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         join_ff       <= 1'b0;
         carry_ff      <= '0;
         carry_pend_ff <= 1'b0;
         np_ff         <= '0;
         blk_cnt_ff    <= '0;
         b_valid_ff    <= 1'b0;
         seen_ff       <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         join_ff       <= join_in;
         carry_ff      <= carry_in;
         carry_pend_ff <= carry_pend_in;
         np_ff         <= np_in;
         blk_cnt_ff    <= blk_cnt_in;
         b_valid_ff    <= step;
         seen_ff       <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      pos_ff    <= pos_in;
      b_pos_ff  <= POS_W'(blk_cnt_ff);
      b_ok_ff   <= idx_ok;
      b_last_ff <= done;
      b_end_ff  <= sec_end;
   end

   // palette store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (pal_wr) begin
         pal_mem[AW'(cmd.slot)] <= {cmd.water, cmd.color};
      end
      if (step && idx_ok) begin
         rd_ff <= pal_mem[AW'(idx)];
      end
   end

   always_comb begin
      color   = b_ok_ff ? rd_ff[COLOR_W-1:0] : '0;
      hit     = b_ok_ff && (cfg.span_mode == SPAN_LEGACY || color != '0);
      any_now = seen_ff || hit;
      seen_in = seen_ff;
      if (b_valid_ff) begin
         seen_in = b_end_ff ? 1'b0 : any_now;
      end
   end

   assign rsp_push                = b_valid_ff;
   assign rsp_data.block_color    = color;
   assign rsp_data.block_water    = b_ok_ff && rd_ff[COLOR_W];
   assign rsp_data.block_position = b_pos_ff;
   assign rsp_data.any_block      = any_now;
   assign rsp_data.last           = b_last_ff;
   assign rsp_data.section_end    = b_end_ff;

endmodule

`default_nettype wire

[rtl/ppiu_checker.sv]
// ppiu_checker: port-level checks of the unpacker over time, bound to the top level
// depends on ppiu_pkg
`default_nettype none

module ppiu_checker
   import ppiu_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             empty,
   input wire logic             pop,
   input wire logic             pready,
   input wire logic [POS_W-1:0] rsp_block_position,
   input wire logic             rsp_last,
   input wire logic             rsp_section_end
);

   logic [POS_W-1:0] exp_pos_ff, exp_pos_in;

   // block positions run up by one per result and restart after a section end
   always_comb begin
      exp_pos_in = exp_pos_ff;
      if (pop && !empty) begin
         exp_pos_in = rsp_section_end ? '0 : rsp_block_position + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_pos_ff <= '0;
      end else begin
         exp_pos_ff <= exp_pos_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_block_position))
      else $error("waiting result changed or vanished");

   a_position: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_block_position == exp_pos_ff)
      else $error("block position out of sequence");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_section_end |-> rsp_last)
      else $error("section end without last mark");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

endmodule

bind packed_palette_index_unpacker ppiu_checker u_ppiu_checker (
   .clock              (clock),
   .reset              (reset),
   .empty              (empty),
   .pop                (pop),
   .pready             (pready),
   .rsp_block_position (rsp_block_position),
   .rsp_last           (rsp_last),
   .rsp_section_end    (rsp_section_end)
);

`default_nettype wire

[sim/packed_palette_index_unpacker_tb.sv]
// packed_palette_index_unpacker_tb: self-checking bench for the palette index unpacker,
// with a beat-level predictor, a queue-fed driver, a result monitor and apb register setup
// depends on ppiu_pkg and packed_palette_index_unpacker
module packed_palette_index_unpacker_tb
   import ppiu_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLOCKS_PER_SECTION = 4096;
   localparam int PALETTE_DEPTH      = 4096;
   localparam int MAX_INDEX_BITS     = 16;
   localparam int LIMIT_CYCLES       = 400000;
   localparam int SETTLE_CYCLES      = 12;
   localparam int PRINT_CAP          = 40;
   localparam int RANDOM_PHASES      = 8;
   localparam int PHASE_ITEMS        = 4;
   // low palette entries written up front; palette sizes of the random phases stay within them
   localparam int PAL_FILLED         = 16;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic                 func;
      logic [SLOT_W-1:0]    slot;
      logic [COLOR_W-1:0]   color;
      logic                 water;
      logic [WORD_BITS-1:0] word;
   } req_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic                  req_func = FUNC_PAL_WRITE;
   logic [SLOT_W-1:0]     req_pal_slot = '0;
   logic [COLOR_W-1:0]    req_pal_color = '0;
   logic                  req_pal_water = 1'b0;
   logic [WORD_BITS-1:0]  req_data_word = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [COLOR_W-1:0]    rsp_block_color;
   logic                  rsp_block_water;
   logic [POS_W-1:0]      rsp_block_position;
   logic                  rsp_any_block;
   logic                  rsp_last;
   logic                  rsp_section_end;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   packed_palette_index_unpacker #(
      .BLOCKS_PER_SECTION(BLOCKS_PER_SECTION),
      .PALETTE_DEPTH(PALETTE_DEPTH),
      .MAX_INDEX_BITS(MAX_INDEX_BITS)
   ) dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_func(req_func), .req_pal_slot(req_pal_slot), .req_pal_color(req_pal_color),
      .req_pal_water(req_pal_water), .req_data_word(req_data_word),
      .empty(empty), .pop(pop),
      .rsp_block_color(rsp_block_color), .rsp_block_water(rsp_block_water),
      .rsp_block_position(rsp_block_position), .rsp_any_block(rsp_any_block),
      .rsp_last(rsp_last), .rsp_section_end(rsp_section_end),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // register copies and section state of the predictor
   logic               span_q = RST_SPAN_MODE;
   logic [BSIZE_W-1:0] bsize_q = RST_BIT_SIZE;
   logic [PSIZE_W-1:0] psize_q = RST_PALETTE_SIZE;
   logic [8:0]         palette_copy [PALETTE_DEPTH];
   int                 bit_pos_q = 0;
   logic [15:0]        carry_q = '0;
   bit                 carry_pend_q = 1'b0;
   logic [12:0]        blk_count_q = '0;
   bit                 seen_q = 1'b0;

   req_beat_type items_waiting[$];
   rsp_type      blocks_due[$];
   req_beat_type beat_out;
   bit           req_taken = 1'b0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           n_items_queued = 0;
   int           n_items_taken = 0;
   int           n_blocks_seen = 0;
   int           n_sections = 0;
   int           n_settings = 0;
   int           n_errors = 0;
   int           cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < PALETTE_DEPTH; i++) palette_copy[i] = '0;
   end

   task automatic report_mismatch(input string msg);
      n_errors++;
      if (n_errors <= PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
   endtask

   function automatic void restart_section();
      bit_pos_q = 0;
      carry_q = '0;
      carry_pend_q = 1'b0;
      blk_count_q = '0;
      seen_q = 1'b0;
   endfunction

   // one block result; returns 1 when it closes the section
   function automatic bit emit_block(input logic [15:0] idx);
      rsp_type    r;
      logic [8:0] entry;
      bit         ok;
      bit         fin;
      ok = (idx < psize_q) && (idx < PALETTE_DEPTH);
      entry = ok ? palette_copy[idx[11:0]] : 9'd0;
      if (ok && (span_q == SPAN_LEGACY || entry[7:0] != 8'd0)) seen_q = 1'b1;
      fin = (blk_count_q >= BLOCKS_PER_SECTION - 1);
      r.block_color = entry[7:0];
      r.block_water = entry[8];
      r.block_position = blk_count_q[11:0];
      r.any_block = seen_q;
      r.last = 1'b0;
      r.section_end = fin;
      blocks_due.insert(blocks_due.size(), r);
      blk_count_q++;
      if (fin) begin
         restart_section();
         n_sections++;
      end
      return fin;
   endfunction

   function automatic void unpack_word(input logic [WORD_BITS-1:0] w);
      int          b;
      int          pos;
      int          np;
      int          sh;
      bit          produced;
      logic [63:0] mask;
      logic [63:0] idx;
      b = bsize_q;
      if (b < 1) b = 1;
      if (b > MAX_INDEX_BITS) b = MAX_INDEX_BITS;
      mask = (64'd1 << b) - 64'd1;
      pos = 0;
      produced = 1'b0;
      if (span_q == SPAN_ALIGNED) begin
         carry_pend_q = 1'b0;
         carry_q = '0;
         bit_pos_q = 0;
         while (pos + b <= WORD_BITS) begin
            produced = 1'b1;
            idx = (w >> pos) & mask;
            if (emit_block(idx[15:0])) break;
            pos += b;
         end
      end else begin
         if (carry_pend_q) begin
            // index split across words: low bits carried, the rest from this word
            np = bit_pos_q;
            sh = (b > np) ? b - np : 0;
            idx = ({48'd0, carry_q} | (w << sh)) & mask;
            carry_pend_q = 1'b0;
            carry_q = '0;
            bit_pos_q = 0;
            produced = 1'b1;
            if (emit_block(idx[15:0])) pos = WORD_BITS;
            else pos = np;
         end
         while (pos < WORD_BITS) begin
            if (pos + b <= WORD_BITS) begin
               produced = 1'b1;
               idx = (w >> pos) & mask;
               if (emit_block(idx[15:0])) break;
               pos += b;
            end else begin
               idx = (w >> pos) & mask;
               carry_q = idx[15:0];
               bit_pos_q = pos + b - WORD_BITS;
               carry_pend_q = 1'b1;
               break;
            end
         end
      end
      if (produced) blocks_due[blocks_due.size() - 1].last = 1'b1;
   endfunction

   // driver: a beat stays up until taken
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_taken) begin
         if (items_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            beat_out = items_waiting.pop_front();
            push <= 1'b1;
            req_func <= beat_out.func;
            req_pal_slot <= beat_out.slot;
            req_pal_color <= beat_out.color;
            req_pal_water <= beat_out.water;
            req_data_word <= beat_out.word;
         end else begin
            push <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      pop <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // input beats feed the predictor, result beats are checked against it
   always @(posedge clock) begin
      rsp_type want;
      req_taken = !reset && push && !full;
      if (req_taken) begin
         n_items_taken++;
         if (req_func == FUNC_PAL_WRITE) palette_copy[req_pal_slot] = {req_pal_water, req_pal_color};
         else unpack_word(req_data_word);
      end
      if (!reset && pop && !empty) begin
         n_blocks_seen++;
         if (blocks_due.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = blocks_due.pop_front();
            if (rsp_block_color !== want.block_color)
               report_mismatch($sformatf("pos %0d color got %0d want %0d", want.block_position,
                                         rsp_block_color, want.block_color));
            if (rsp_block_water !== want.block_water)
               report_mismatch($sformatf("pos %0d water got %0b want %0b", want.block_position,
                                         rsp_block_water, want.block_water));
            if (rsp_block_position !== want.block_position)
               report_mismatch($sformatf("position got %0d want %0d", rsp_block_position,
                                         want.block_position));
            if (rsp_any_block !== want.any_block)
               report_mismatch($sformatf("pos %0d any_block got %0b want %0b",
                                         want.block_position, rsp_any_block, want.any_block));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("pos %0d last got %0b want %0b", want.block_position,
                                         rsp_last, want.last));
            if (rsp_section_end !== want.section_end)
               report_mismatch($sformatf("pos %0d section_end got %0b want %0b",
                                         want.block_position, rsp_section_end,
                                         want.section_end));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  blocks_due.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 82;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct = 82;
         end
         default: begin
            send_idle_pct = 16;
            recv_stall_pct = 16;
         end
      endcase
   endtask

   task automatic csr_access(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_reg(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] rd;
      csr_access(idx, 1'b0, '0, rd);
      if (rd !== value)
         report_mismatch($sformatf("register %0d reads %0h want %0h", idx, rd, value));
   endtask

   task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] rd;
      csr_access(idx, 1'b1, value, rd);
      case (idx)
         REG_SPAN_MODE:    span_q = value[0];
         REG_BIT_SIZE:     bsize_q = value[BSIZE_W-1:0];
         REG_PALETTE_SIZE: psize_q = value[PSIZE_W-1:0];
         default: ;
      endcase
      check_reg(idx, value);
   endtask

   task automatic configure(input logic mode, input int bsize, input int psize);
      set_reg(REG_SPAN_MODE, 32'(mode));
      set_reg(REG_BIT_SIZE, 32'(bsize));
      set_reg(REG_PALETTE_SIZE, 32'(psize));
      n_settings++;
   endtask

   task automatic queue_item(input logic func, input logic [SLOT_W-1:0] slot,
                             input logic [COLOR_W-1:0] color, input logic water,
                             input logic [WORD_BITS-1:0] w);
      req_beat_type it;
      it.func = func;
      it.slot = slot;
      it.color = color;
      it.water = water;
      it.word = w;
      items_waiting.insert(items_waiting.size(), it);
      n_items_queued++;
   endtask

   // unused fields of a beat carry random values too
   task automatic queue_word(input logic [WORD_BITS-1:0] w);
      queue_item(FUNC_DATA_WORD, SLOT_W'($urandom), COLOR_W'($urandom), 1'($urandom), w);
   endtask

   task automatic queue_pal(input logic [SLOT_W-1:0] slot);
      logic [COLOR_W-1:0] c;
      c = ($urandom_range(7) == 0) ? '0 : COLOR_W'($urandom_range(255));
      queue_item(FUNC_PAL_WRITE, slot, c, 1'($urandom), {$urandom, $urandom});
   endtask

   function automatic logic [WORD_BITS-1:0] random_word();
      logic [WORD_BITS-1:0] w;
      w = {$urandom, $urandom};
      // sparse words keep many indices below small palette sizes
      if ($urandom_range(1) == 1) w &= {$urandom, $urandom} & {$urandom, $urandom};
      return w;
   endfunction

   task automatic wait_idle(input bit settle);
      while (n_items_taken != n_items_queued || blocks_due.size() != 0) @(negedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int remaining;
      int bsize;
      int psize;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_reg(REG_SPAN_MODE, 32'(RST_SPAN_MODE));
      check_reg(REG_BIT_SIZE, 32'(RST_BIT_SIZE));
      check_reg(REG_PALETTE_SIZE, 32'(RST_PALETTE_SIZE));

      // low entries and the few high ones the wide-index words hit get written first
      set_idle(IDLE_NONE);
      for (int s = 0; s < PAL_FILLED; s++) queue_pal(SLOT_W'(s));
      queue_pal(12'h800);
      queue_pal(12'hffe);
      queue_pal(12'hfff);
      queue_word('1);
      queue_word('0);
      wait_idle(1'b1);

      // legacy, 3-bit: indices straddle word boundaries
      configure(SPAN_LEGACY, 3, 4096);
      queue_word('1);
      queue_word(64'h0123_4567_89ab_cdef);
      queue_word('0);
      wait_idle(1'b1);

      // widest index: out of range above the palette depth, edge entries
      configure(SPAN_ALIGNED, 16, 4096);
      queue_word({16'hffff, 16'h1000, 16'h0fff, 16'h0000});
      queue_word(64'h0fff_0ffe_0001_0000);
      wait_idle(1'b1);

      // carry left pending, then bit size shrinks below the carried part
      configure(SPAN_LEGACY, 5, PAL_FILLED);
      queue_word(random_word());
      wait_idle(1'b1);
      configure(SPAN_LEGACY, 1, 100);
      queue_word(random_word());
      wait_idle(1'b1);

      // carry left pending, then an aligned word drops it
      configure(SPAN_LEGACY, 5, PAL_FILLED);
      queue_word(random_word());
      wait_idle(1'b1);
      configure(SPAN_ALIGNED, 5, PAL_FILLED);
      queue_word(random_word());
      wait_idle(1'b1);

      // bit sizes outside the legal range
      configure(SPAN_LEGACY, 0, 1);
      queue_word(random_word());
      wait_idle(1'b1);
      configure(SPAN_ALIGNED, 31, 4096);
      queue_word(64'h0000_0fff_0800_0001);
      wait_idle(1'b1);

      // run a legacy section to its end, usually mid-word
      configure(SPAN_LEGACY, 1, 8);
      remaining = BLOCKS_PER_SECTION - blk_count_q;
      for (int i = 0; i < (remaining + 63) / 64 + 2; i++) queue_word({$urandom, $urandom});
      wait_idle(1'b1);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: bsize = 1;
            1: bsize = 16;
            2: bsize = 0;
            3: bsize = 31;
            default: bsize = $urandom_range(31);
         endcase
         case (ph)
            0: psize = 0;
            1: psize = PAL_FILLED;
            default: psize = $urandom_range(PAL_FILLED);
         endcase
         configure(1'($urandom), bsize, psize);
         set_idle(idle_mode_type'(ph % 4));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(4) == 0) queue_pal(SLOT_W'($urandom));
            else queue_word(random_word());
            // sender holds off until the block has drained
            if (ph == 2 && i == PHASE_ITEMS / 2 - 1) wait_idle(1'b0);
         end
         wait_idle(1'b1);
      end

      set_idle(IDLE_NONE);
      wait_idle(1'b1);
      $display("covered %0d beats in and %0d blocks out, %0d section wraps,", n_items_taken,
               n_blocks_seen, n_sections);
      $display("both span modes over %0d register settings including size extremes",
               n_settings);
      if (n_errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
rtl/ppiu_pkg.sv
rtl/ppiu_fifo.sv
rtl/ppiu_csr.sv
rtl/ppiu_front.sv
rtl/ppiu_back.sv
rtl/packed_palette_index_unpacker.sv
rtl/ppiu_checker.sv
sim/packed_palette_index_unpacker_tb.sv
